/* src/tlv_stream_parser_macros.svh */
// Assertion macros used by the parser's result queue module.
`ifndef TLV_STREAM_PARSER_MACROS_SVH
`define TLV_STREAM_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define TLV_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("tlv_stream_parser: assertion failed");

// The condition must never be true outside reset.
`define TLV_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("tlv_stream_parser: forbidden condition seen");

`else

`define TLV_ASSERT(lbl, clk, rstn, prop)
`define TLV_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

/* src/tlvsp_pkg.sv */
package tlvsp_pkg;

  localparam logic [15:0] MaxRecordLen = 16'd4096;

  // Result kinds.
  localparam logic [1:0] KindHeader = 2'd0;
  localparam logic [1:0] KindValue  = 2'd1;
  localparam logic [1:0] KindDone   = 2'd2;
  localparam logic [1:0] KindError  = 2'd3;

  // Status codes.
  localparam logic [1:0] StatOk        = 2'd0;
  localparam logic [1:0] StatTruncated = 2'd1;
  localparam logic [1:0] StatBadMagic  = 2'd2;
  localparam logic [1:0] StatTooBig    = 2'd3;

  // Configuration register indexes.
  localparam logic RegMagicWord = 1'b0;
  localparam logic RegQueryType = 1'b1;

  // Result queue geometry.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [31:0] magic_word;
    logic [7:0]  query_type;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  rec_type;
    logic [12:0] rec_len;
    logic [15:0] rec_index;
    logic [27:0] blob_offset;
    logic [7:0]  value_byte;
    logic [1:0]  status;
    logic [15:0] record_count;
    logic [27:0] type_total;
    logic        last_of_run;
  } result_t;

  // Up to two results caused by one input beat, in order.
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } res_pair_t;

endpackage

/* src/tlvsp_core.sv */
module tlvsp_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_input_i,
  input  tlvsp_pkg::cfg_t       cfg_i,
  output tlvsp_pkg::res_pair_t  res_o
);

  localparam logic [2:0] PhMagic = 3'd0;
  localparam logic [2:0] PhCount = 3'd1;
  localparam logic [2:0] PhType  = 3'd2;
  localparam logic [2:0] PhLen   = 3'd3;
  localparam logic [2:0] PhValue = 3'd4;
  localparam logic [2:0] PhDrain = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  pos_q, pos_d;
  logic        magic_ok_q, magic_ok_d;
  logic [7:0]  latch_q, latch_d;
  logic [15:0] recs_left_q, recs_left_d;
  logic [15:0] rec_num_q, rec_num_d;
  logic [7:0]  cur_type_q, cur_type_d;
  logic [12:0] cur_len_q, cur_len_d;
  logic [12:0] val_left_q, val_left_d;
  logic [28:0] offset_q, offset_d;
  logic [28:0] matched_q, matched_d;

  logic                 prim_v, end_v, fin, done, failed;
  logic [1:0]           fail_status;
  logic [15:0]          word;
  logic [31:0]          magic_shift;
  tlvsp_pkg::result_t   prim_res, end_res;

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    magic_ok_d  = magic_ok_q;
    latch_d     = latch_q;
    recs_left_d = recs_left_q;
    rec_num_d   = rec_num_q;
    cur_type_d  = cur_type_q;
    cur_len_d   = cur_len_q;
    val_left_d  = val_left_q;
    offset_d    = offset_q;
    matched_d   = matched_q;
    prim_v      = 1'b0;
    end_v       = 1'b0;
    fin         = 1'b0;
    done        = 1'b0;
    failed      = 1'b0;
    fail_status = tlvsp_pkg::StatOk;
    prim_res    = '0;
    end_res     = '0;
    word        = {data_byte_i, latch_q};
    magic_shift = cfg_i.magic_word >> {pos_q, 3'b000};

    case (phase_q)
      PhMagic: begin
        if (data_byte_i != magic_shift[7:0]) begin
          magic_ok_d = 1'b0;
        end
        if (pos_q == 2'd3) begin
          pos_d   = 2'd0;
          phase_d = PhCount;
        end else begin
          pos_d = pos_q + 2'd1;
        end
      end
      PhCount: begin
        if (pos_q == 2'd0) begin
          latch_d = data_byte_i;
          pos_d   = 2'd1;
        end else begin
          pos_d       = 2'd0;
          recs_left_d = word;
          if (!magic_ok_q) begin
            failed      = 1'b1;
            fail_status = tlvsp_pkg::StatBadMagic;
          end else if (word == 16'd0) begin
            done = 1'b1;
          end else begin
            phase_d = PhType;
          end
        end
      end
      PhType: begin
        cur_type_d = data_byte_i;
        pos_d      = 2'd0;
        phase_d    = PhLen;
      end
      PhLen: begin
        if (pos_q == 2'd0) begin
          latch_d = data_byte_i;
          pos_d   = 2'd1;
        end else begin
          pos_d = 2'd0;
          if (word > tlvsp_pkg::MaxRecordLen) begin
            failed      = 1'b1;
            fail_status = tlvsp_pkg::StatTooBig;
          end else begin
            cur_len_d  = word[12:0];
            val_left_d = word[12:0];
            prim_v     = 1'b1;
            prim_res.kind        = tlvsp_pkg::KindHeader;
            prim_res.rec_type    = cur_type_q;
            prim_res.rec_len     = word[12:0];
            prim_res.rec_index   = rec_num_q;
            prim_res.blob_offset = offset_q[27:0];
            if (cur_type_q == cfg_i.query_type) begin
              matched_d = matched_q + {16'd0, word[12:0]};
            end
            if (word[12:0] == 13'd0) begin
              fin = 1'b1;
            end else begin
              phase_d = PhValue;
            end
          end
        end
      end
      PhValue: begin
        prim_v               = 1'b1;
        prim_res.kind        = tlvsp_pkg::KindValue;
        prim_res.rec_type    = cur_type_q;
        prim_res.rec_len     = cur_len_q;
        prim_res.rec_index   = rec_num_q;
        prim_res.blob_offset = offset_q[27:0];
        prim_res.value_byte  = data_byte_i;
        offset_d   = offset_q + 29'd1;
        val_left_d = val_left_q - 13'd1;
        if (val_left_d == 13'd0) begin
          fin = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Closing a record: the document is done once the declared count runs out.
    if (fin) begin
      rec_num_d   = rec_num_q + 16'd1;
      recs_left_d = recs_left_q - 16'd1;
      if (recs_left_d == 16'd0) begin
        done = 1'b1;
      end else begin
        phase_d = PhType;
      end
    end

    if (done) begin
      end_v                = 1'b1;
      end_res.kind         = tlvsp_pkg::KindDone;
      end_res.blob_offset  = offset_d[27:0];
      end_res.record_count = rec_num_d;
      end_res.type_total   = matched_d[27:0];
      phase_d              = PhDrain;
    end else if (failed) begin
      end_v          = 1'b1;
      end_res.kind   = tlvsp_pkg::KindError;
      end_res.status = fail_status;
      phase_d        = PhDrain;
    end else if (end_of_input_i && phase_d != PhDrain) begin
      end_v          = 1'b1;
      end_res.kind   = tlvsp_pkg::KindError;
      end_res.status = tlvsp_pkg::StatTruncated;
    end

    // The last beat of a document always leaves the parser as after reset.
    if (end_of_input_i) begin
      phase_d     = PhMagic;
      pos_d       = 2'd0;
      magic_ok_d  = 1'b1;
      latch_d     = '0;
      recs_left_d = '0;
      rec_num_d   = '0;
      cur_type_d  = '0;
      cur_len_d   = '0;
      val_left_d  = '0;
      offset_d    = '0;
      matched_d   = '0;
    end

    end_res.last_of_run = 1'b1;
    prim_res.last_of_run = !end_v;
    res_o.num    = {1'b0, prim_v} + {1'b0, end_v};
    res_o.first  = prim_v ? prim_res : end_res;
    res_o.second = end_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhMagic;
      pos_q       <= 2'd0;
      magic_ok_q  <= 1'b1;
      latch_q     <= '0;
      recs_left_q <= '0;
      rec_num_q   <= '0;
      cur_type_q  <= '0;
      cur_len_q   <= '0;
      val_left_q  <= '0;
      offset_q    <= '0;
      matched_q   <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      magic_ok_q  <= magic_ok_d;
      latch_q     <= latch_d;
      recs_left_q <= recs_left_d;
      rec_num_q   <= rec_num_d;
      cur_type_q  <= cur_type_d;
      cur_len_q   <= cur_len_d;
      val_left_q  <= val_left_d;
      offset_q    <= offset_d;
      matched_q   <= matched_d;
    end
  end

endmodule

/* src/tlvsp_queue.sv */
`include "tlv_stream_parser_macros.svh"

module tlvsp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tlvsp_pkg::res_pair_t res_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 stall_i,
  output tlvsp_pkg::result_t   head_o
);

  localparam int PtrW = tlvsp_pkg::QPtrW;
  localparam int CntW = tlvsp_pkg::QCntW;

  tlvsp_pkg::result_t entries_q [tlvsp_pkg::QDepth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_next;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      push_n;
  logic            pop;

  assign push_n  = push_i ? res_i.num : 2'd0;
  assign pop     = valid_o && !stall_i;
  assign valid_o = cnt_q != '0;
  assign head_o  = entries_q[rd_ptr_q];
  assign wr_next = wr_ptr_q + PtrW'(1);
  // Room is judged on the registered fill so that it never waits on the consumer.
  assign room_o  = cnt_q <= CntW'(tlvsp_pkg::QDepth - 2);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_n);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(push_n) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      entries_q[wr_ptr_q] <= res_i.first;
    end
    if (push_n == 2'd2) begin
      entries_q[wr_next] <= res_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `TLV_ASSERT_NEVER(a_fill_bound, clk_i, rst_ni, cnt_q > CntW'(tlvsp_pkg::QDepth))
  `TLV_ASSERT(a_pair_fits, clk_i, rst_ni, (push_n == 2'd2) |-> (cnt_q <= CntW'(tlvsp_pkg::QDepth - 2)))
  `TLV_ASSERT(a_empty_stays, clk_i, rst_ni, (cnt_q == '0 && push_n == 2'd0) |=> (cnt_q == '0))
  `TLV_ASSERT(a_ptr_gap, clk_i, rst_ni, (cnt_q == '0 || cnt_q == CntW'(tlvsp_pkg::QDepth)) |-> (wr_ptr_q == rd_ptr_q))

endmodule

/* src/tlv_stream_parser.sv */
// Channel  | Handshake             | Beat payload
// input    | in_valid_i/in_stall_o | data_byte_i, end_of_input_i
// output   | out_valid_o/out_stall_i | kind_o .. last_of_run_o (ten fields)
// config   | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One input beat is taken per cycle unless stalled; the parser state updates at the
// accepting edge. Each beat yields up to two results, which go into a four-entry
// result queue and leave one per cycle unless stalled, so a header and a terminating
// result leave in turn. Input stalls while the queue holds more than two results.
// Reset clears parser state, configuration and queue; no clearing pass is needed.
module tlv_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  rec_type_o,
  output logic [12:0] rec_len_o,
  output logic [15:0] rec_index_o,
  output logic [27:0] blob_offset_o,
  output logic [7:0]  value_byte_o,
  output logic [1:0]  status_o,
  output logic [15:0] record_count_o,
  output logic [27:0] type_total_o,
  output logic        last_of_run_o
);

  tlvsp_pkg::cfg_t      cfg_q;
  tlvsp_pkg::res_pair_t res;
  tlvsp_pkg::result_t   head;
  logic                 room, accept;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tlvsp_pkg::RegMagicWord: cfg_q.magic_word <= cfg_data_i;
        tlvsp_pkg::RegQueryType: cfg_q.query_type <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  tlvsp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .cfg_i          (cfg_q),
    .res_o          (res)
  );

  tlvsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .res_i   (res),
    .room_o  (room),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .head_o  (head)
  );

  assign kind_o         = head.kind;
  assign rec_type_o     = head.rec_type;
  assign rec_len_o      = head.rec_len;
  assign rec_index_o    = head.rec_index;
  assign blob_offset_o  = head.blob_offset;
  assign value_byte_o   = head.value_byte;
  assign status_o       = head.status;
  assign record_count_o = head.record_count;
  assign type_total_o   = head.type_total;
  assign last_of_run_o  = head.last_of_run;

endmodule

/* tb/tlv_stream_parser_test.sv */
`timescale 1ns / 1ps

module tlv_stream_parser_test;
  import tlvsp_pkg::*;

  localparam int unsigned LongHold    = 200;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainLimit  = 5000;
  localparam int unsigned PhaseBeats  = 120;

  typedef enum logic [2:0] {
    PhMagic, PhCount, PhType, PhLen, PhValue, PhDrain
  } parse_phase_e;

  // A directed beat; where typed is set, the single result it causes is given here.
  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    logic       typed;
    logic [1:0] kind;
    logic [1:0] status;
  } directed_beat_t;

  localparam directed_beat_t DirectedBeats [26] = '{
    // Empty document under the reset magic, closed on its last count byte.
    '{8'h00, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h00, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h00, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h00, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h00, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h00, 1'b1, 1'b1, KindDone, StatOk},
    // Wrong first magic byte, reported with the second count byte.
    '{8'h80, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h00, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h00, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h00, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h00, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'hFF, 1'b1, 1'b1, KindError, StatBadMagic},
    // Two records: one byte of value, then a length one above the limit.
    '{8'h00, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h00, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h00, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h00, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h02, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h00, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h00, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h01, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h00, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'hFF, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h07, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h01, 1'b0, 1'b0, KindHeader, StatOk},
    '{8'h10, 1'b1, 1'b1, KindError, StatTooBig},
    // A document that ends inside its magic.
    '{8'h5A, 1'b1, 1'b1, KindError, StatTruncated}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        end_of_input_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  rec_type_o;
  logic [12:0] rec_len_o;
  logic [15:0] rec_index_o;
  logic [27:0] blob_offset_o;
  logic [7:0]  value_byte_o;
  logic [1:0]  status_o;
  logic [15:0] record_count_o;
  logic [27:0] type_total_o;
  logic        last_of_run_o;

  tlv_stream_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .end_of_input_i(end_of_input_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .rec_type_o    (rec_type_o),
    .rec_len_o     (rec_len_o),
    .rec_index_o   (rec_index_o),
    .blob_offset_o (blob_offset_o),
    .value_byte_o  (value_byte_o),
    .status_o      (status_o),
    .record_count_o(record_count_o),
    .type_total_o  (type_total_o),
    .last_of_run_o (last_of_run_o)
  );

  // Parser state as the block should hold it.
  logic [31:0]  magic_cfg;
  logic [7:0]   query_cfg;
  parse_phase_e ph;
  logic [1:0]   pos;
  logic         magic_good;
  logic [7:0]   low_latch;
  logic [15:0]  recs_left;
  logic [15:0]  rec_num;
  logic [7:0]   cur_type;
  logic [12:0]  cur_len;
  logic [12:0]  val_left;
  logic [28:0]  blob_pos;
  logic [28:0]  type_sum;

  result_t     step_out[$];
  result_t     pending_results[$];
  int unsigned beats_taken;
  int unsigned items_sent;
  int unsigned errors;
  logic        beat_typed;
  logic [1:0]  beat_kind;
  logic [1:0]  beat_status;
  logic        tx_idle_on;
  logic        rx_idle_on;
  logic        hold_req;

  function automatic void clear_doc();
    ph         = PhMagic;
    pos        = '0;
    magic_good = 1'b1;
    low_latch  = '0;
    recs_left  = '0;
    rec_num    = '0;
    cur_type   = '0;
    cur_len    = '0;
    val_left   = '0;
    blob_pos   = '0;
    type_sum   = '0;
  endfunction

  function automatic result_t make_result(logic [1:0] kind, logic [7:0] vbyte,
                                          logic [1:0] status, logic with_rec,
                                          logic [28:0] off);
    result_t r;
    r = '0;
    r.kind = kind;
    if (with_rec) begin
      r.rec_type  = cur_type;
      r.rec_len   = cur_len;
      r.rec_index = rec_num;
    end
    r.blob_offset = off[27:0];
    r.value_byte  = vbyte;
    r.status      = status;
    if (kind == KindDone) begin
      r.record_count = rec_num;
      r.type_total   = type_sum[27:0];
    end
    return r;
  endfunction

  // Closes the current record and tells whether the document is complete.
  function automatic logic close_record();
    rec_num   = rec_num + 16'd1;
    recs_left = recs_left - 16'd1;
    if (recs_left == 16'd0) begin
      ph = PhDrain;
      return 1'b1;
    end
    ph = PhType;
    return 1'b0;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eoi);
    logic [15:0] len;
    logic        done;
    logic        failed;
    done   = 1'b0;
    failed = 1'b0;
    step_out.delete();
    case (ph)
      PhMagic: begin
        if (b != magic_cfg[{pos, 3'b000} +: 8]) magic_good = 1'b0;
        if (pos == 2'd3) begin
          pos = '0;
          ph  = PhCount;
        end else begin
          pos = pos + 2'd1;
        end
      end
      PhCount: begin
        if (pos == 2'd0) begin
          low_latch = b;
          pos       = 2'd1;
        end else begin
          pos       = '0;
          recs_left = {b, low_latch};
          if (!magic_good) begin
            step_out.push_back(make_result(KindError, 8'h00, StatBadMagic, 1'b0, '0));
            failed = 1'b1;
          end else if (recs_left == 16'd0) begin
            done = 1'b1;
          end else begin
            ph = PhType;
          end
        end
      end
      PhType: begin
        cur_type = b;
        pos      = '0;
        ph       = PhLen;
      end
      PhLen: begin
        if (pos == 2'd0) begin
          low_latch = b;
          pos       = 2'd1;
        end else begin
          len = {b, low_latch};
          pos = '0;
          if (len > MaxRecordLen) begin
            step_out.push_back(make_result(KindError, 8'h00, StatTooBig, 1'b0, '0));
            failed = 1'b1;
          end else begin
            cur_len  = len[12:0];
            val_left = cur_len;
            step_out.push_back(make_result(KindHeader, 8'h00, StatOk, 1'b1, blob_pos));
            if (cur_type == query_cfg) type_sum = type_sum + {16'd0, cur_len};
            if (val_left == 13'd0) done = close_record();
            else ph = PhValue;
          end
        end
      end
      PhValue: begin
        step_out.push_back(make_result(KindValue, b, StatOk, 1'b1, blob_pos));
        blob_pos = blob_pos + 29'd1;
        val_left = val_left - 13'd1;
        if (val_left == 13'd0) done = close_record();
      end
      default: ;
    endcase

    if (done) begin
      step_out.push_back(make_result(KindDone, 8'h00, StatOk, 1'b0, blob_pos));
      ph = PhDrain;
    end else if (failed) begin
      ph = PhDrain;
    end else if (eoi && ph != PhDrain) begin
      step_out.push_back(make_result(KindError, 8'h00, StatTruncated, 1'b0, '0));
    end
    if (eoi) clear_doc();
    if (step_out.size() != 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 7) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Input beats are predicted before results are checked; a result cannot leave in the
  // same cycle as its beat, since the queue stores it in a register first.
  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        beats_taken++;
        parse_byte(data_byte_i, end_of_input_i);
        if (beat_typed) begin
          want             = '0;
          want.kind        = beat_kind;
          want.status      = beat_status;
          want.last_of_run = 1'b1;
          pending_results.push_back(want);
        end else begin
          foreach (step_out[i]) pending_results.push_back(step_out[i]);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{kind: kind_o, rec_type: rec_type_o, rec_len: rec_len_o,
                rec_index: rec_index_o, blob_offset: blob_offset_o,
                value_byte: value_byte_o, status: status_o,
                record_count: record_count_o, type_total: type_total_o,
                last_of_run: last_of_run_o};
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t ns: expected no result, got kind %0d status %0d", $time,
                   got.kind, got.status);
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("rec_type", want.rec_type, got.rec_type);
          check_field("rec_len", want.rec_len, got.rec_len);
          check_field("rec_index", want.rec_index, got.rec_index);
          check_field("blob_offset", want.blob_offset, got.blob_offset);
          check_field("value_byte", want.value_byte, got.value_byte);
          check_field("status", want.status, got.status);
          check_field("record_count", want.record_count, got.record_count);
          check_field("type_total", want.type_total, got.type_total);
          check_field("last_of_run", want.last_of_run, got.last_of_run);
        end
      end
    end
  end

  // Receiver stalls: random bursts, or one long hold-off when asked for.
  initial begin : rx_stall_gen
    int unsigned stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (LongHold) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_req    = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
        out_stall_i = 1'b1;
        stall_left  = gap_len();
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  // Valid is left high between back-to-back beats.
  task automatic send_beat(logic [7:0] b, logic eoi, logic typed, logic [1:0] t_kind,
                           logic [1:0] t_status);
    int unsigned taken0;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i     = 1'b0;
      data_byte_i    = $urandom;
      end_of_input_i = $urandom;
      repeat (gap_len()) @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    data_byte_i    = b;
    end_of_input_i = eoi;
    beat_typed     = typed;
    beat_kind      = t_kind;
    beat_status    = t_status;
    taken0         = beats_taken;
    do @(negedge clk_i); while (beats_taken == taken0);
    items_sent++;
  endtask

  task automatic wait_drained();
    int unsigned guard;
    guard      = 0;
    in_valid_i = 1'b0;
    while (pending_results.size() != 0 && guard < DrainLimit) begin
      @(negedge clk_i);
      guard++;
    end
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t ns: expected %0d more results, got none", $time,
               pending_results.size());
      pending_results.delete();
    end
    // Trailing beats cause no result, so give the block time to settle.
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == RegMagicWord) magic_cfg = value;
    else query_cfg = value[7:0];
  endtask

  // Mostly well-formed documents with random content; the rest carry a wrong magic, a
  // huge record count, a cut, trailing bytes, plain noise or an over-long record.
  task automatic send_random_doc(logic full_len);
    logic [7:0]  doc[$];
    logic [31:0] m;
    logic [15:0] n_recs;
    logic [15:0] len;
    int unsigned style;
    int unsigned built;
    int unsigned pick;
    int unsigned cut;
    style = $urandom_range(0, 9);
    if (full_len) style = 9;
    m     = magic_cfg;
    if (style == 0) m = m ^ (32'h1 << $urandom_range(0, 31));
    if (style == 1) n_recs = '0;
    else if (style == 2) n_recs = $urandom_range(256, 65535);
    else n_recs = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) doc.push_back(m[8*i +: 8]);
    doc.push_back(n_recs[7:0]);
    doc.push_back(n_recs[15:8]);
    built = (n_recs > 16'd4) ? 3 : n_recs;
    for (int r = 0; r < built; r++) begin
      doc.push_back($urandom_range(0, 1) ? query_cfg : 8'($urandom));
      pick = $urandom_range(0, 14);
      if (full_len && r == 0) len = MaxRecordLen;
      else if (pick == 0) len = $urandom_range(MaxRecordLen + 1, 65535);
      else if (pick < 3) len = $urandom_range(9, 40);
      else len = $urandom_range(0, 8);
      doc.push_back(len[7:0]);
      doc.push_back(len[15:8]);
      if (len > MaxRecordLen) break;
      // The largest record is only begun, and the document ends inside it.
      if (full_len && r == 0) begin
        repeat (3) doc.push_back($urandom);
        break;
      end
      for (int k = 0; k < len; k++) doc.push_back($urandom);
    end
    if (style == 3) begin
      cut = $urandom_range(1, doc.size() - 1);
      doc = doc[0:cut-1];
    end else if (style == 4) begin
      doc.delete();
      repeat ($urandom_range(1, 8)) doc.push_back($urandom);
    end else if (style == 5) begin
      repeat ($urandom_range(1, 3)) doc.push_back($urandom);
    end
    foreach (doc[k]) send_beat(doc[k], k == doc.size() - 1, 1'b0, KindHeader, StatOk);
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = RegMagicWord;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    data_byte_i    = '0;
    end_of_input_i = 1'b0;
    beat_typed     = 1'b0;
    beat_kind      = KindHeader;
    beat_status    = StatOk;
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    hold_req       = 1'b0;
    beats_taken    = 0;
    items_sent     = 0;
    errors         = 0;
    magic_cfg      = '0;
    query_cfg      = '0;
    clear_doc();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DirectedBeats[i])
      send_beat(DirectedBeats[i].data, DirectedBeats[i].eoi, DirectedBeats[i].typed,
                DirectedBeats[i].kind, DirectedBeats[i].status);
    wait_drained();

    // Top extremes of both registers; a record header of the largest length.
    write_reg(RegMagicWord, 32'hFFFF_FFFF);
    write_reg(RegQueryType, 32'hFFFF_FFFF);
    send_random_doc(1'b1);
    phase_start = items_sent;
    while (items_sent - phase_start < PhaseBeats) send_random_doc(1'b0);
    wait_drained();

    // Random registers, idling on both sides and one long receiver hold-off.
    write_reg(RegMagicWord, $urandom);
    write_reg(RegQueryType, $urandom);
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    hold_req    = 1'b1;
    phase_start = items_sent;
    while (items_sent - phase_start < PhaseBeats) send_random_doc(1'b0);
    wait_drained();

    // Bottom extremes, with only the sender idling.
    write_reg(RegMagicWord, 32'h0);
    write_reg(RegQueryType, 32'h0);
    rx_idle_on  = 1'b0;
    phase_start = items_sent;
    while (items_sent - phase_start < PhaseBeats) send_random_doc(1'b0);
    wait_drained();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/tlvsp_pkg.sv
src/tlvsp_core.sv
src/tlvsp_queue.sv
src/tlv_stream_parser.sv
tb/tlv_stream_parser_test.sv
